// ===== src/nts_pkg.sv =====
package nts_pkg;

    localparam int BYTE_W      = 8;
    localparam int NIBBLE_W    = 4;
    localparam int KEY_W       = 8;
    localparam int LEN_W       = 5;
    localparam int TYPE_W      = 3;
    localparam int COUNT_W     = 16;
    localparam int CONTENT_W   = 64;
    localparam int TABLE_DEPTH = 256;

    // nibbles a token result carries, and token results one byte may cause
    localparam int TOKEN_NIBBLES     = 16;
    localparam int MAX_TOKEN_RESULTS = 19;
    localparam int RESULT_CNT_W      = 5;

    // request kinds on the input tuser bit
    localparam logic REQ_TABLE  = 1'b0;
    localparam logic REQ_STREAM = 1'b1;

    // token table entry, 11 bits
    typedef struct packed {
        logic [TYPE_W-1:0] kind;
        logic              nop;
        logic              ext;
        logic              rare;
        logic [LEN_W-1:0]  length;
    } table_entry_t;

    localparam int ENTRY_W = $bits(table_entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOOK,
        ST_COUNT
    } scan_state_t;

endpackage

// ===== src/nts_ram.sv =====
module nts_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/nibble_token_rare_scanner.sv =====
// Rare-token scanner for a nibble-packed byte stream.
//
// Input channel (s_*): one transfer is either a token table write (tuser = 0)
// or a stream byte (tuser = 1, tlast marks the last byte of a buffer). Load
// the 256-entry table before streaming; an entry never written reads as junk.
// Result channel (m_*): token results (tuser = 0) carry 64 bits of stream
// from the token start and the rare type; the count result (tuser = 1) closes
// every buffer with the number of rare tokens emitted.
//
// Flow: one item at a time. After a stream byte is accepted, the scanner
// drops consumed bytes from the lookahead window, skips extension keys,
// decodes tokens (the table memory has a registered read, so each lookup
// passes through a look state) and ends on a check that finds no further
// token; a byte that arrives after the capacity is reached is accepted and
// dropped. The count result is loaded in a state of its own.
//
// Reset (aresetn low, synchronous) clears the stream state and sets the
// capacity to 65535; the table is not cleared. A stalled receiver holds the
// result register; the scanner waits on it before loading the next result
// and keeps accepting items whenever it is idle.
module nibble_token_rare_scanner #(
    parameter int MAX_TOKEN_LENGTH = 18,
    parameter int LOOKAHEAD_BYTES  = 10
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // output_capacity

    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_key[7:0], entry_length[12:8], entry_rare[13], entry_ext[14],
    // entry_nop[15], entry_rare_type[18:16], data_byte[26:19], zero[31:27]
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,       // req_type
    input  logic        s_tlast,       // end_of_buffer

    output logic        m_tvalid,
    input  logic        m_tready,
    // token_contents[63:0], token_type[66:64], token_count[82:67], zero[87:83]
    output logic [87:0] m_tdata,
    output logic        m_tuser        // is_count
);

    import nts_pkg::*;

    localparam int WIN_W  = LOOKAHEAD_BYTES * BYTE_W;
    localparam int FILL_W = $clog2(LOOKAHEAD_BYTES + 1);
    localparam int SKIP_W = $clog2(MAX_TOKEN_LENGTH + 2);
    localparam int CMP_W  = FILL_W + SKIP_W + 3;

    // ---------------------------------------------------------------------
    // Input field unpacking
    // ---------------------------------------------------------------------
    logic [KEY_W-1:0]  in_key;
    logic [LEN_W-1:0]  in_length;
    logic [LEN_W-1:0]  in_length_sat;
    logic [BYTE_W-1:0] in_byte;
    table_entry_t      in_entry;

    assign in_key    = s_tdata[7:0];
    assign in_length = s_tdata[12:8];
    assign in_byte   = s_tdata[26:19];

    // Saturate overlong lengths on the way into the table
    assign in_length_sat = (in_length > LEN_W'(MAX_TOKEN_LENGTH))
                         ? LEN_W'(MAX_TOKEN_LENGTH) : in_length;

    assign in_entry.length = in_length_sat;
    assign in_entry.rare   = s_tdata[13];
    assign in_entry.ext    = s_tdata[14];
    assign in_entry.nop    = s_tdata[15];
    assign in_entry.kind   = s_tdata[18:16];

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    scan_state_t             state_reg, state_next;
    logic [COUNT_W-1:0]      capacity_reg, capacity_next;
    logic [WIN_W-1:0]        window_reg, window_next;     // bytes past fill stay zero
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [SKIP_W-1:0]       skip_reg, skip_next;
    logic                    ext_mode_reg, ext_mode_next;
    logic [COUNT_W-1:0]      emitted_reg, emitted_next;
    logic                    cap_hit_reg, cap_hit_next;
    logic                    eob_reg, eob_next;
    logic [RESULT_CNT_W-1:0] results_reg, results_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    out_is_count_reg, out_is_count_next;
    logic [CONTENT_W-1:0]    out_contents_reg, out_contents_next;
    logic [TYPE_W-1:0]       out_type_reg, out_type_next;
    logic [COUNT_W-1:0]      out_count_reg, out_count_next;

    // ---------------------------------------------------------------------
    // Token table
    // ---------------------------------------------------------------------
    logic             ram_we;
    logic [KEY_W-1:0] key_now;
    logic [ENTRY_W-1:0] ram_rdata;
    table_entry_t     entry;

    assign ram_we = s_tvalid && s_tready && (s_tuser == REQ_TABLE);
    assign entry  = table_entry_t'(ram_rdata);

    // Read address follows the current token key; it holds steady while the
    // looked-up entry is in use, so the read data holds too.
    nts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (in_key),
        .wr_data (in_entry),
        .rd_addr (key_now),
        .rd_data (ram_rdata)
    );

    // ---------------------------------------------------------------------
    // Shared conditions
    // ---------------------------------------------------------------------
    logic                 accept;
    logic                 in_stream;
    logic                 at_cap;
    logic                 start_cap;
    logic                 can_shift;
    logic                 no_more;
    logic                 res_full;
    logic                 ext_skip;
    logic                 out_free;
    logic [COUNT_W-1:0]   emitted_inc;
    logic                 cap_after;
    logic [CMP_W-1:0]     fill_nibbles;
    logic [CMP_W-1:0]     skip_wide;
    logic [CONTENT_W-1:0] contents_now;
    logic [SKIP_W-1:0]    advance;

    assign accept    = s_tvalid && s_tready;
    assign in_stream = (s_tuser == REQ_STREAM);
    assign at_cap    = (emitted_reg >= capacity_reg);
    assign start_cap = cap_hit_reg || at_cap;
    assign can_shift = (skip_reg >= SKIP_W'(2)) && (fill_reg != '0);

    assign fill_nibbles = CMP_W'({fill_reg, 1'b0});
    assign skip_wide    = CMP_W'(skip_reg);

    // At buffer end decode while any held nibble remains; otherwise wait
    // until a full token's worth of nibbles is held.
    assign no_more = eob_reg ? (skip_wide >= fill_nibbles)
                             : (fill_nibbles < skip_wide + CMP_W'(TOKEN_NIBBLES));
    assign res_full = (results_reg >= RESULT_CNT_W'(MAX_TOKEN_RESULTS));

    // After the byte drop the token start is nibble 0 or 1 of the window
    assign key_now      = skip_reg[0] ? window_reg[NIBBLE_W +: KEY_W]
                                      : window_reg[0 +: KEY_W];
    assign contents_now = skip_reg[0] ? window_reg[NIBBLE_W +: CONTENT_W]
                                      : window_reg[0 +: CONTENT_W];
    assign ext_skip     = ext_mode_reg && key_now[0];

    assign out_free    = !out_valid_reg || m_tready;
    assign emitted_inc = emitted_reg + COUNT_W'(1);
    assign cap_after   = (emitted_inc >= capacity_reg);
    assign advance     = (entry.length == '0) ? SKIP_W'(1) : SKIP_W'(entry.length);

    // ---------------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && in_stream) begin
                    if (!start_cap) begin
                        state_next = ST_SCAN;
                    end else if (s_tlast) begin
                        state_next = ST_COUNT;
                    end
                end
            end
            ST_SCAN: begin
                if (can_shift) begin
                    state_next = ST_SCAN;
                end else if (at_cap || no_more || res_full) begin
                    state_next = eob_reg ? ST_COUNT : ST_IDLE;
                end else if (!ext_skip) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (!entry.rare) begin
                    state_next = ST_SCAN;
                end else if (out_free) begin
                    if (cap_after) begin
                        state_next = eob_reg ? ST_COUNT : ST_IDLE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_COUNT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Datapath and outputs
    // ---------------------------------------------------------------------
    always_comb begin
        capacity_next     = capacity_reg;
        window_next       = window_reg;
        fill_next         = fill_reg;
        skip_next         = skip_reg;
        ext_mode_next     = ext_mode_reg;
        emitted_next      = emitted_reg;
        cap_hit_next      = cap_hit_reg;
        eob_next          = eob_reg;
        results_next      = results_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_is_count_next = out_is_count_reg;
        out_contents_next = out_contents_reg;
        out_type_next     = out_type_reg;
        out_count_next    = out_count_reg;
        s_tready          = (state_reg == ST_IDLE);

        if (cfg_wr_en) begin
            capacity_next = cfg_wr_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && in_stream) begin
                    eob_next     = s_tlast;
                    results_next = '0;
                    cap_hit_next = start_cap;
                    // Append at the fill position unless capped or window full
                    if (!start_cap && (fill_reg < FILL_W'(LOOKAHEAD_BYTES))) begin
                        for (int i = 0; i < LOOKAHEAD_BYTES; i++) begin
                            if (fill_reg == FILL_W'(i)) begin
                                window_next[i*BYTE_W +: BYTE_W] = in_byte;
                            end
                        end
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
            end
            ST_SCAN: begin
                if (can_shift) begin
                    // Drop one consumed byte from the window head
                    window_next = window_reg >> BYTE_W;
                    fill_next   = fill_reg - FILL_W'(1);
                    skip_next   = skip_reg - SKIP_W'(2);
                end else if (at_cap) begin
                    cap_hit_next = 1'b1;
                end else if (!no_more && !res_full && ext_skip) begin
                    skip_next = skip_reg + SKIP_W'(2);
                end
            end
            ST_LOOK: begin
                if (entry.rare) begin
                    if (out_free) begin
                        out_valid_next    = 1'b1;
                        out_is_count_next = 1'b0;
                        out_contents_next = contents_now;
                        out_type_next     = entry.kind;
                        out_count_next    = '0;
                        emitted_next      = emitted_inc;
                        results_next      = results_reg + RESULT_CNT_W'(1);
                        if (cap_after) begin
                            // Stop here: position and mode stay as they are
                            cap_hit_next = 1'b1;
                        end else begin
                            if (!entry.nop) begin
                                ext_mode_next = entry.ext;
                            end
                            skip_next = skip_reg + advance;
                        end
                    end
                end else begin
                    if (!entry.nop) begin
                        ext_mode_next = entry.ext;
                    end
                    skip_next = skip_reg + advance;
                end
            end
            ST_COUNT: begin
                if (out_free) begin
                    out_valid_next    = 1'b1;
                    out_is_count_next = 1'b1;
                    out_contents_next = '0;
                    out_type_next     = '0;
                    out_count_next    = emitted_reg;
                    // Return the stream state to its reset values
                    window_next       = '0;
                    fill_next         = '0;
                    skip_next         = '0;
                    ext_mode_next     = 1'b0;
                    emitted_next      = '0;
                    cap_hit_next      = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= '1;
            window_reg    <= '0;
            fill_reg      <= '0;
            skip_reg      <= '0;
            ext_mode_reg  <= 1'b0;
            emitted_reg   <= '0;
            cap_hit_reg   <= 1'b0;
            eob_reg       <= 1'b0;
            results_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            capacity_reg  <= capacity_next;
            window_reg    <= window_next;
            fill_reg      <= fill_next;
            skip_reg      <= skip_next;
            ext_mode_reg  <= ext_mode_next;
            emitted_reg   <= emitted_next;
            cap_hit_reg   <= cap_hit_next;
            eob_reg       <= eob_next;
            results_reg   <= results_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_is_count_reg <= out_is_count_next;
        out_contents_reg <= out_contents_next;
        out_type_reg     <= out_type_next;
        out_count_reg    <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_is_count_reg;
    assign m_tdata  = {5'b0, out_count_reg, out_type_reg, out_contents_reg};

endmodule

// ===== dv/nibble_token_rare_scanner_tb.sv =====
module nibble_token_rare_scanner_tb;

    import nts_pkg::*;

    localparam int MAX_LEN        = 18;
    localparam int WINDOW_BYTES   = 10;
    localparam int CLK_PERIOD     = 8;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int RANDOM_ITEMS   = 100;
    localparam int SETTLE_CYCLES  = 64;

    // one transfer on the result channel, unpacked
    typedef struct packed {
        logic                 is_count;
        logic [CONTENT_W-1:0] contents;
        logic [TYPE_W-1:0]    kind;
        logic [COUNT_W-1:0]   count;
    } scan_result_t;

    // Scoreboard: mirrors the scanner state, turns every accepted input transfer
    // into the results it causes and checks the result stream in order.
    class scan_scoreboard;
        table_entry_t   token_tab [TABLE_DEPTH];
        logic [7:0]     window [WINDOW_BYTES];
        int unsigned    fill;
        int unsigned    skip;
        bit             ext_mode;
        bit             cap_hit;
        int unsigned    emitted;
        int unsigned    capacity;
        scan_result_t   due_results [$];
        int             errors;

        function new();
            capacity = 65535;
            errors   = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            foreach (window[i]) window[i] = '0;
            fill     = 0;
            skip     = 0;
            ext_mode = 1'b0;
            emitted  = 0;
            cap_hit  = 1'b0;
        endfunction

        function void set_capacity(logic [COUNT_W-1:0] value);
            capacity = int'(value);
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function logic [NIBBLE_W-1:0] nibble_at(int unsigned pos);
            int unsigned b;
            b = pos >> 1;
            if (b >= fill || b >= WINDOW_BYTES) return '0;
            return pos[0] ? window[b][7:4] : window[b][3:0];
        endfunction

        function void note_transfer(logic req, logic last, logic [31:0] data);
            table_entry_t   e;
            logic [4:0]     len;
            logic [7:0]     key;
            scan_result_t   r;
            int             n;
            n = 0;
            if (req == REQ_TABLE) begin
                len = data[12:8];
                if (len > 5'(MAX_LEN)) len = 5'(MAX_LEN);
                e.length = len;
                e.rare   = data[13];
                e.ext    = data[14];
                e.nop    = data[15];
                e.kind   = data[18:16];
                token_tab[data[7:0]] = e;
                return;
            end
            if (emitted >= capacity) cap_hit = 1'b1;
            if (!cap_hit) begin
                if (fill < WINDOW_BYTES) begin
                    window[fill] = data[26:19];
                    fill++;
                end
                while (1) begin
                    // drop whole bytes that lie before the token start
                    while (skip >= 2 && fill > 0) begin
                        for (int i = 0; i < WINDOW_BYTES - 1; i++) window[i] = window[i+1];
                        window[WINDOW_BYTES-1] = '0;
                        fill--;
                        skip -= 2;
                    end
                    if (emitted >= capacity) begin
                        cap_hit = 1'b1;
                        break;
                    end
                    if (last) begin
                        if (skip >= 2 * fill) break;
                    end else if (2 * fill < skip + TOKEN_NIBBLES) begin
                        break;
                    end
                    if (n >= MAX_TOKEN_RESULTS) break;
                    key = {nibble_at(skip + 1), nibble_at(skip)};
                    if (ext_mode && key[0]) begin
                        skip += 2;
                        continue;
                    end
                    e = token_tab[key];
                    if (e.rare) begin
                        r.is_count = 1'b0;
                        r.kind     = e.kind;
                        r.count    = '0;
                        for (int k = 0; k < TOKEN_NIBBLES; k++)
                            r.contents[4*k +: 4] = nibble_at(skip + k);
                        due_results.push_back(r);
                        n++;
                        emitted = (emitted + 1) & 16'hFFFF;
                        if (emitted >= capacity) begin
                            cap_hit = 1'b1;
                            break;
                        end
                    end
                    if (!e.nop) ext_mode = e.ext;
                    skip += (e.length != 0) ? int'(e.length) : 1;
                end
            end
            if (last) begin
                r.is_count = 1'b1;
                r.contents = '0;
                r.kind     = '0;
                r.count    = emitted[15:0];
                due_results.push_back(r);
                clear_stream();
            end
        endfunction

        function void check_result(logic is_count, logic [87:0] data);
            scan_result_t want;
            scan_result_t got;
            got.is_count = is_count;
            got.contents = data[63:0];
            got.kind     = data[66:64];
            got.count    = data[82:67];
            if (due_results.size() == 0) begin
                $display("%0t: expected no result, actual is_count=%0b contents=%h type=%0d count=%0d",
                         $time, got.is_count, got.contents, got.kind, got.count);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.is_count !== want.is_count) begin
                $display("%0t: is_count mismatch, expected %0b actual %0b",
                         $time, want.is_count, got.is_count);
                errors++;
            end
            if (got.contents !== want.contents) begin
                $display("%0t: token_contents mismatch, expected %h actual %h",
                         $time, want.contents, got.contents);
                errors++;
            end
            if (got.kind !== want.kind) begin
                $display("%0t: token_type mismatch, expected %0d actual %0d",
                         $time, want.kind, got.kind);
                errors++;
            end
            if (got.count !== want.count) begin
                $display("%0t: token_count mismatch, expected %0d actual %0d",
                         $time, want.count, got.count);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;      // entry_key, entry_length, rare, ext, nop, type, data_byte
    logic        s_tuser;      // req_type
    logic        s_tlast;      // end_of_buffer
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;      // token_contents, token_type, token_count
    logic        m_tuser;      // is_count

    scan_scoreboard sb = new();

    // sender burst bookkeeping
    int burst_left = 0;
    // items sent in the random part
    int random_items = 0;

    nibble_token_rare_scanner #(
        .MAX_TOKEN_LENGTH (MAX_LEN),
        .LOOKAHEAD_BYTES  (WINDOW_BYTES)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Hard stop: end the run if the stream ever hangs.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: pick a stall pattern, hold it for a while, then switch.
    // Pattern 0 never stalls, the others stall lightly, heavily or for long runs.
    initial begin
        int ready_mode;
        m_tready = 1'b0;
        forever begin
            ready_mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 80)) begin
                @(negedge aclk);
                case (ready_mode)
                    0: m_tready = 1'b1;
                    1: m_tready = ($urandom_range(0, 1) == 1);
                    2: m_tready = ($urandom_range(0, 3) == 0);
                    default: m_tready = ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    // Monitor: every result transfer goes straight to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready)
            sb.check_result(m_tuser, m_tdata);
    end

    // Stream nibbles come from a small set so that only a few keys are ever
    // looked up; the set still toggles every bit of a nibble.
    function automatic logic [3:0] pick_nibble(int idx);
        case (idx)
            0: return 4'h0;
            1: return 4'h5;
            2: return 4'hA;
            default: return 4'hF;
        endcase
    endfunction

    function automatic logic [7:0] random_byte();
        return {pick_nibble($urandom_range(0, 3)), pick_nibble($urandom_range(0, 3))};
    endfunction

    // Pack a table write; the data byte field is don't-care, so fill it with noise.
    function automatic logic [31:0] entry_payload(logic [7:0] key, logic [4:0] len,
                                                  logic rare, logic ext, logic nop,
                                                  logic [2:0] rtype);
        logic [7:0] noise;
        noise = 8'($urandom_range(0, 255));
        return {5'b0, noise, rtype, nop, ext, rare, len, key};
    endfunction

    // Pack a stream byte; the table entry fields are don't-care.
    function automatic logic [31:0] byte_payload(logic [7:0] b);
        logic [18:0] noise;
        noise = 19'($urandom);
        return {5'b0, b, noise};
    endfunction

    // Drive one input transfer. Call at a falling edge; return at a falling edge.
    // Open a new burst when the old one is used up, possibly after a gap.
    task automatic send_transfer(input logic req, input logic last, input logic [31:0] payload);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tlast  = last;
        s_tdata  = payload;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_transfer(req, last, payload);
        @(negedge aclk);
    endtask

    task automatic table_write(input logic [7:0] key, input logic [4:0] len, input logic rare,
                               input logic ext, input logic nop, input logic [2:0] rtype,
                               input logic last = 1'b0);
        send_transfer(REQ_TABLE, last, entry_payload(key, len, rare, ext, nop, rtype));
    endtask

    task automatic stream_byte(input logic [7:0] b, input logic last);
        send_transfer(REQ_STREAM, last, byte_payload(b));
    endtask

    // Random entry: mostly short tokens so that rare results come often,
    // now and then a long or overlong one and an out-of-range type code.
    task automatic random_table_write(input logic [7:0] key, input logic last);
        int         pick;
        logic [4:0] len;
        logic [2:0] rtype;
        pick = $urandom_range(0, 19);
        if (pick < 14)      len = 5'($urandom_range(0, 4));
        else if (pick < 19) len = 5'($urandom_range(5, 18));
        else                len = 5'($urandom_range(19, 31));
        rtype = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
        table_write(key, len, ($urandom_range(0, 1) == 1), ($urandom_range(0, 2) == 0),
                    ($urandom_range(0, 3) == 0), rtype, last);
    endtask

    // Drop valid, wait for every expected result, then let the block settle.
    task automatic drain();
        s_tvalid = 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write the capacity register; only called while the block is idle.
    task automatic write_capacity(input logic [15:0] value);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        sb.set_capacity(value);
    endtask

    initial begin
        logic [7:0] palette [6];
        logic [7:0] b;
        logic [7:0] key;
        int         buffers;
        int         buf_len;
        int         phase;
        logic [15:0] cap;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        s_tlast     = 1'b0;

        // hold reset, release at a falling edge
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        write_capacity(16'hFFFF);

        // Fill every entry that the stream can reach first.
        for (int hi = 0; hi < 4; hi++)
            for (int lo = 0; lo < 4; lo++)
                random_table_write({pick_nibble(hi), pick_nibble(lo)}, 1'b0);

        // Directed part.
        // zero length advances one nibble; type 7 passes through; enters extension mode
        table_write(8'h00, 5'd0, 1'b1, 1'b1, 1'b0, 3'd7);
        // overlong length saturates; no-op keeps extension mode
        table_write(8'hFF, 5'd31, 1'b1, 1'b0, 1'b1, 3'd4);
        // plain token that enters extension mode
        table_write(8'h05, 5'd2, 1'b0, 1'b1, 1'b0, 3'd0);
        // longest legal token, leaves extension mode
        table_write(8'h50, 5'd18, 1'b1, 1'b0, 1'b0, 3'd5);
        table_write(8'hA5, 5'd19, 1'b1, 1'b0, 1'b0, 3'd6);
        // one-byte buffer: token runs past the end and is zero-filled
        stream_byte(8'hFF, 1'b1);
        // extension skips on odd keys, then a table write in mid-buffer
        stream_byte(8'h05, 1'b0);
        stream_byte(8'h0F, 1'b0);
        stream_byte(8'h00, 1'b0);
        stream_byte(8'h50, 1'b0);
        stream_byte(8'hFF, 1'b0);
        stream_byte(8'hA5, 1'b0);
        table_write(8'hA5, 5'd1, 1'b0, 1'b0, 1'b1, 3'd2);
        stream_byte(8'hA5, 1'b0);
        stream_byte(8'h55, 1'b0);
        stream_byte(8'hAA, 1'b0);
        stream_byte(8'h00, 1'b0);
        stream_byte(8'h50, 1'b0);
        stream_byte(8'hFF, 1'b0);
        stream_byte(8'h05, 1'b0);
        // end of buffer flushes the lookahead
        stream_byte(8'h00, 1'b1);
        stream_byte(8'h00, 1'b1);
        drain();

        // Random part: phases with their own capacity, first the lowest,
        // then mixed values, always a return to the highest at the end.
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (phase == 0) begin
                cap = 16'd1;
            end else begin
                case ($urandom_range(0, 3))
                    0: cap = 16'($urandom_range(2, 6));
                    1: cap = 16'($urandom_range(1, 65535));
                    2: cap = 16'hFFFF;
                    default: cap = 16'($urandom_range(1, 20));
                endcase
            end
            write_capacity(cap);
            foreach (palette[i]) palette[i] = random_byte();
            buffers = $urandom_range(2, 4);
            repeat (buffers) begin
                if (random_items < RANDOM_ITEMS) begin
                    buf_len = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 36)
                                                          : $urandom_range(1, 20);
                    for (int i = 0; i < buf_len; i++) begin
                        // now and then rewrite an entry between bytes
                        if ($urandom_range(0, 11) == 0) begin
                            key = ($urandom_range(0, 1) == 0) ? random_byte()
                                                              : 8'($urandom_range(0, 255));
                            random_table_write(key, ($urandom_range(0, 1) == 1));
                            random_items++;
                        end
                        b = ($urandom_range(0, 2) == 0) ? palette[$urandom_range(0, 5)]
                                                        : random_byte();
                        stream_byte(b, i == buf_len - 1);
                        random_items++;
                    end
                end
            end
            drain();
            phase++;
        end
        write_capacity(16'hFFFF);
        buf_len = $urandom_range(4, 10);
        for (int i = 0; i < buf_len; i++)
            stream_byte(random_byte(), i == buf_len - 1);
        drain();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
